// ===== sv/thq_pkg.sv =====
// Shared types, constants and helper functions for the terrain height query block.
`timescale 1ns / 1ps

package thq_pkg;

	// Grid geometry and storage.
	localparam int MAX_GRID_DIM = 256;
	localparam int STORE_DEPTH  = MAX_GRID_DIM * MAX_GRID_DIM;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);
	localparam int DIM_W        = 9;
	localparam int POS_W        = 8;
	localparam int SAMPLE_W     = 8;
	localparam int GAIN_W       = 16;
	localparam int HGT_W        = 24;

	// Fixed-point formats.
	localparam int FRAC     = 8;
	localparam int Q_W      = 20;
	localparam int CX_W     = 21;
	localparam int CELL_W   = CX_W - FRAC;
	localparam int DIFF_W   = HGT_W + 1;
	localparam int WT_W     = CX_W + 1;
	localparam int PROD_W   = DIFF_W + WT_W;
	localparam int SUM_W    = PROD_W + 2;
	localparam int OUT_W    = 32;
	localparam int ONE_Q    = 1 << FRAC;
	localparam int ROUND_Q  = 1 << (FRAC - 1);

	// Queue between the front and back parts.
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_GAIN = 2'd2;
	localparam int CFG_DATA_W = 16;

	localparam logic [DIM_W-1:0]  GRID_DIM_RESET = DIM_W'(MAX_GRID_DIM);
	localparam logic [GAIN_W-1:0] GAIN_RESET     = 16'd13;

	// Request function codes.
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Effective configuration, with grid sizes already clamped.
	typedef struct packed {
		logic [DIM_W-1:0]  rows;
		logic [DIM_W-1:0]  cols;
		logic [GAIN_W-1:0] gain;
	} cfg_t;

	// One classified request on its way from the front to the back.
	typedef struct packed {
		logic                   func;
		logic                   wr_ok;
		logic [ADDR_W-1:0]      addr;
		logic [HGT_W-1:0]       wdata;
		logic signed [CX_W-1:0] dx;
		logic signed [CX_W-1:0] dz;
	} entry_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_READ,
		B_WAIT,
		B_MUL,
		B_SUM
	} back_state_t;

	// Clamp a programmed grid dimension to the supported range.
	function automatic logic [DIM_W-1:0] dim_eff(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] r;
		if (d < DIM_W'(2)) begin
			r = DIM_W'(2);
		end else if (d > DIM_W'(MAX_GRID_DIM)) begin
			r = DIM_W'(MAX_GRID_DIM);
		end else begin
			r = d;
		end
		return r;
	endfunction

endpackage

// ===== sv/thq_front.sv =====
// Front part: accepts requests, locates the query cell and forms store addresses.
`timescale 1ns / 1ps

module thq_front import thq_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       start,
	output logic                       busy,
	input  logic                       func,
	input  logic [POS_W-1:0]           sample_row,
	input  logic [POS_W-1:0]           sample_col,
	input  logic [SAMPLE_W-1:0]        sample_value,
	input  logic signed [Q_W-1:0]      query_x,
	input  logic signed [Q_W-1:0]      query_z,
	input  logic                       q_full,
	output logic                       push,
	output entry_t                     push_entry
);

	logic                   s1_valid_q;
	logic                   func_s1;
	logic [POS_W-1:0]       row_s1;
	logic [POS_W-1:0]       col_s1;
	logic [SAMPLE_W-1:0]    value_s1;
	logic signed [Q_W-1:0]  qx_s1;
	logic signed [Q_W-1:0]  qz_s1;

	logic                   s2_valid_q;
	logic                   func_s2;
	logic                   wr_ok_s2;
	logic [POS_W-1:0]       row_s2;
	logic [POS_W-1:0]       col_s2;
	logic [SAMPLE_W-1:0]    value_s2;
	logic signed [CX_W-1:0] dx_s2;
	logic signed [CX_W-1:0] dz_s2;

	logic s2_free;
	logic s1_move;
	logic accept;

	// Stage two drains into the queue; stage one moves when stage two has room.
	assign s2_free = !s2_valid_q || !q_full;
	assign s1_move = s1_valid_q && s2_free;
	assign busy    = s1_valid_q && !s2_free;
	assign accept  = start && !busy;
	assign push    = s2_valid_q && !q_full;

	// Stage one registers the request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_move) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= func;
			row_s1   <= sample_row;
			col_s1   <= sample_col;
			value_s1 <= sample_value;
			qx_s1    <= query_x;
			qz_s1    <= query_z;
		end
	end

	// Center the query on the grid, floor to a cell and clamp it.
	logic [POS_W-1:0]        cols_m1, rows_m1;
	logic [DIM_W-1:0]        col_hi, row_hi;
	logic signed [CX_W-1:0]  cx, cz;
	logic signed [CELL_W-1:0] col_raw, row_raw;
	logic [POS_W-1:0]        col_cl, row_cl;
	logic signed [CX_W-1:0]  dx, dz;
	logic                    wr_ok;

	always_comb begin
		cols_m1 = POS_W'(cfg.cols - DIM_W'(1));
		rows_m1 = POS_W'(cfg.rows - DIM_W'(1));
		col_hi  = cfg.cols - DIM_W'(2);
		row_hi  = cfg.rows - DIM_W'(2);
		cx = $signed({{(CX_W-POS_W-FRAC+1){1'b0}}, cols_m1, {(FRAC-1){1'b0}}})
			+ CX_W'(qx_s1);
		cz = $signed({{(CX_W-POS_W-FRAC+1){1'b0}}, rows_m1, {(FRAC-1){1'b0}}})
			- CX_W'(qz_s1);
		col_raw = cx[CX_W-1:FRAC];
		row_raw = cz[CX_W-1:FRAC];

		if (col_raw[CELL_W-1]) begin
			col_cl = '0;
		end else if (col_raw[CELL_W-2:0] > (CELL_W-1)'(col_hi)) begin
			col_cl = POS_W'(col_hi);
		end else begin
			col_cl = col_raw[POS_W-1:0];
		end

		if (row_raw[CELL_W-1]) begin
			row_cl = '0;
		end else if (row_raw[CELL_W-2:0] > (CELL_W-1)'(row_hi)) begin
			row_cl = POS_W'(row_hi);
		end else begin
			row_cl = row_raw[POS_W-1:0];
		end

		// Offsets inside the cell may leave [0, 1) once the cell is clamped.
		dx = cx - $signed({{(CX_W-POS_W-FRAC){1'b0}}, col_cl, {FRAC{1'b0}}});
		dz = cz - $signed({{(CX_W-POS_W-FRAC){1'b0}}, row_cl, {FRAC{1'b0}}});

		wr_ok = (DIM_W'(row_s1) < cfg.rows) && (DIM_W'(col_s1) < cfg.cols);
	end

	// Stage two holds the cell or sample position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s2_free) begin
			s2_valid_q <= s1_move;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			func_s2  <= func_s1;
			wr_ok_s2 <= wr_ok;
			row_s2   <= (func_s1 == FUNC_QUERY) ? row_cl : row_s1;
			col_s2   <= (func_s1 == FUNC_QUERY) ? col_cl : col_s1;
			value_s2 <= value_s1;
			dx_s2    <= dx;
			dz_s2    <= dz;
		end
	end

	// Linear store address and scaled sample.
	logic [POS_W+DIM_W-1:0] addr_full;

	always_comb begin
		addr_full = (POS_W+DIM_W)'(row_s2) * (POS_W+DIM_W)'(cfg.cols)
			+ (POS_W+DIM_W)'(col_s2);
		push_entry.func  = func_s2;
		push_entry.wr_ok = wr_ok_s2;
		push_entry.addr  = addr_full[ADDR_W-1:0];
		push_entry.wdata = HGT_W'(value_s2) * HGT_W'(cfg.gain);
		push_entry.dx    = dx_s2;
		push_entry.dz    = dz_s2;
	end

endmodule

// ===== sv/thq_fifo.sv =====
// Short request queue that decouples the front part from the back part.
`timescale 1ns / 1ps

module thq_fifo import thq_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output logic   full,
	output logic   empty
);

	entry_t            slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QDEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ===== sv/thq_back.sv =====
// Back part: owns the height store, performs writes and interpolates queries.
`timescale 1ns / 1ps

module thq_back import thq_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [DIM_W-1:0]        cols,
	input  entry_t                  head,
	input  logic                    empty,
	output logic                    pop,
	output logic                    done,
	output logic signed [OUT_W-1:0] height,
	output logic                    saturated
);

	logic [HGT_W-1:0] mem [STORE_DEPTH];

	back_state_t            state_q, state_d;
	logic [1:0]             cnt_q;
	logic [ADDR_W-1:0]      base_q;
	logic signed [CX_W-1:0] dx_q, dz_q;
	logic [HGT_W-1:0]       rdata_q;
	logic                   rvalid_q;
	logic [1:0]             ridx_q;
	logic [HGT_W-1:0]       corner_q [4];
	logic [HGT_W-1:0]       a_q;
	logic signed [PROD_W-1:0] p1_q, p2_q;
	logic                   done_q;
	logic signed [OUT_W-1:0] height_q;
	logic                   sat_q;

	logic              mem_we, mem_re, load, mul_en, out_en;
	logic [ADDR_W-1:0] mem_addr, corner_off;

	// Corner order: the cell's own corner, same row next column, next row same column, diagonal.
	always_comb begin
		case (cnt_q)
			2'd0:    corner_off = '0;
			2'd1:    corner_off = ADDR_W'(1);
			2'd2:    corner_off = ADDR_W'(cols);
			default: corner_off = ADDR_W'(cols) + ADDR_W'(1);
		endcase
	end

	// Sequencer: one write per cycle while idle and the queue holds writes, or four corner reads then the arithmetic.
	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		load     = 1'b0;
		mul_en   = 1'b0;
		out_en   = 1'b0;
		mem_addr = base_q + corner_off;
		unique case (state_q)
			B_IDLE: begin
				mem_addr = head.addr;
				if (!empty) begin
					pop = 1'b1;
					if (head.func == FUNC_WRITE) begin
						mem_we = head.wr_ok;
					end else begin
						load    = 1'b1;
						state_d = B_READ;
					end
				end
			end
			B_READ: begin
				mem_re = 1'b1;
				if (cnt_q == 2'd3) begin
					state_d = B_WAIT;
				end
			end
			B_WAIT: begin
				state_d = B_MUL;
			end
			B_MUL: begin
				mul_en  = 1'b1;
				state_d = B_SUM;
			end
			B_SUM: begin
				out_en  = 1'b1;
				state_d = B_IDLE;
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			cnt_q    <= '0;
			rvalid_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			rvalid_q <= mem_re;
			done_q   <= out_en;
			if (load) begin
				cnt_q <= '0;
			end else if (mem_re) begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	// Height store, single port with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= head.wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	// Query context and corner capture.
	always_ff @(posedge clk) begin
		if (load) begin
			base_q <= head.addr;
			dx_q   <= head.dx;
			dz_q   <= head.dz;
		end
		ridx_q <= cnt_q;
		if (rvalid_q) begin
			corner_q[ridx_q] <= rdata_q;
		end
	end

	// Pick the triangle and form the two weighted differences.
	logic signed [WT_W-1:0]   dsum, dxe, dze, w1, w2;
	logic signed [DIFF_W-1:0] d1, d2;
	logic                     lower;
	logic [HGT_W-1:0]         a_sel;

	always_comb begin
		dxe   = WT_W'(dx_q);
		dze   = WT_W'(dz_q);
		dsum  = dxe + dze;
		lower = dsum < $signed(WT_W'(ONE_Q));
		if (lower) begin
			a_sel = corner_q[0];
			d1    = $signed({1'b0, corner_q[1]}) - $signed({1'b0, corner_q[0]});
			d2    = $signed({1'b0, corner_q[2]}) - $signed({1'b0, corner_q[0]});
			w1    = dxe;
			w2    = dze;
		end else begin
			a_sel = corner_q[3];
			d1    = $signed({1'b0, corner_q[2]}) - $signed({1'b0, corner_q[3]});
			d2    = $signed({1'b0, corner_q[1]}) - $signed({1'b0, corner_q[3]});
			w1    = $signed(WT_W'(ONE_Q)) - dxe;
			w2    = $signed(WT_W'(ONE_Q)) - dze;
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			a_q  <= a_sel;
			p1_q <= d1 * w1;
			p2_q <= d2 * w2;
		end
	end

	// Sum, round half up, drop the fraction and saturate to 32 bits.
	logic signed [SUM_W-1:0]       s_sum;
	logic signed [SUM_W-FRAC-1:0]  h_full;
	logic [SUM_W-FRAC-OUT_W:0]     h_top;
	logic                          fits;

	always_comb begin
		s_sum = $signed({{(SUM_W-HGT_W-FRAC){1'b0}}, a_q, {FRAC{1'b0}}})
			+ SUM_W'(p1_q) + SUM_W'(p2_q) + $signed(SUM_W'(ROUND_Q));
		h_full = s_sum[SUM_W-1:FRAC];
		h_top  = h_full[SUM_W-FRAC-1:OUT_W-1];
		fits   = (&h_top) || !(|h_top);
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			sat_q <= !fits;
			if (fits) begin
				height_q <= h_full[OUT_W-1:0];
			end else if (h_full[SUM_W-FRAC-1]) begin
				height_q <= {1'b1, {(OUT_W-1){1'b0}}};
			end else begin
				height_q <= {1'b0, {(OUT_W-1){1'b1}}};
			end
		end
	end

	assign done      = done_q;
	assign height    = height_q;
	assign saturated = sat_q;

endmodule

// ===== sv/terrain_height_query_core.sv =====
// Top level of the terrain height query block: configuration registers and part wiring.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. A write request
// stores sample_value times height_gain at row * grid_cols + col if row
// and col lie inside the grid, and yields no result; a query yields one
// result on height and saturated, marked by done for exactly one cycle. The
// receiver cannot stall, so results must be captured when done is high.
// The back part reads the four cell corners of a query through the single
// port of the height store, one per cycle; a two-entry queue behind a
// two-stage front lets requests arrive while a query is in progress. The
// store is not cleared at reset: every corner a query touches must have
// been written first.
// Configuration writes are always ready and must be made while idle.
module terrain_height_query_core import thq_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    func,
	input  logic [POS_W-1:0]        sample_row,
	input  logic [POS_W-1:0]        sample_col,
	input  logic [SAMPLE_W-1:0]     sample_value,
	input  logic signed [Q_W-1:0]   query_x,
	input  logic signed [Q_W-1:0]   query_z,
	output logic                    done,
	output logic signed [OUT_W-1:0] height,
	output logic                    saturated,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	cfg_t   cfg_q;
	logic   q_push, q_pop, q_full, q_empty;
	entry_t push_entry, head;

	assign cfg_ready = 1'b1;

	// Configuration registers; grid sizes are stored already clamped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rows <= GRID_DIM_RESET;
			cfg_q.cols <= GRID_DIM_RESET;
			cfg_q.gain <= GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GRID_ROWS:   cfg_q.rows <= dim_eff(cfg_data[DIM_W-1:0]);
				REG_GRID_COLS:   cfg_q.cols <= dim_eff(cfg_data[DIM_W-1:0]);
				REG_HEIGHT_GAIN: cfg_q.gain <= cfg_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	thq_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.sample_row   (sample_row),
		.sample_col   (sample_col),
		.sample_value (sample_value),
		.query_x      (query_x),
		.query_z      (query_z),
		.q_full       (q_full),
		.push         (q_push),
		.push_entry   (push_entry)
	);

	thq_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.pop        (q_pop),
		.head       (head),
		.full       (q_full),
		.empty      (q_empty)
	);

	thq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cols      (cfg_q.cols),
		.head      (head),
		.empty     (q_empty),
		.pop       (q_pop),
		.done      (done),
		.height    (height),
		.saturated (saturated)
	);

endmodule

// ===== sv/thq_checker.sv =====
// Port-level checks for the terrain height query block and their bind.
`timescale 1ns / 1ps

module thq_checker import thq_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    done,
	input logic signed [OUT_W-1:0] height,
	input logic                    saturated,
	input logic                    cfg_valid,
	input logic                    cfg_ready
);

	// A query occupies the back part through its read and arithmetic states, so results never abut.
	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobes on two consecutive cycles");

	// A clipped height sits exactly at one end of the 32-bit range.
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |->
			(height == 32'sh7fff_ffff || height == 32'sh8000_0000))
		else $error("saturated result is not a range limit");

	// Configuration requests are never held off.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration request stalled");

	// No result appears in the first cycle after reset is released.
	a_done_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !done)
		else $error("result strobe right after reset");

endmodule

bind terrain_height_query_core thq_checker u_thq_checker (.*);

// ===== test/tb_terrain_height_query_core.sv =====
// Self-checking testbench for the terrain height query core: grid writes, height queries, settings.
`timescale 1ns / 1ps

module tb_terrain_height_query_core;
	import thq_pkg::*;

	localparam int SETTLE_CYCLES = 32;
	localparam int PHASE_ITEMS   = 165;
	localparam int RANDOM_PHASES = 8;
	localparam int GAIN_MAX      = (1 << GAIN_W) - 1;
	localparam int HALF_Q        = ONE_Q / 2;
	// Offset of cell (0, 0) on the full-size grid that is in use after reset.
	localparam int CELL_ORIGIN   = (MAX_GRID_DIM - 1) * HALF_Q;
	// The index field has one code that names no register.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W - 1){1'b0}}};
	localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W - 1){1'b1}}};
	localparam longint HEIGHT_MAX = 64'sd2147483647;
	localparam longint HEIGHT_MIN = -64'sd2147483648;

	typedef struct packed {
		logic                  func;
		logic [POS_W-1:0]      row;
		logic [POS_W-1:0]      col;
		logic [SAMPLE_W-1:0]   value;
		logic signed [Q_W-1:0] qx;
		logic signed [Q_W-1:0] qz;
	} terrain_request_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] height;
		logic                    saturated;
	} height_result_t;

	// Clock, reset and block ports.
	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    start        = 1'b0;
	logic                    busy;
	logic                    func         = FUNC_WRITE;
	logic [POS_W-1:0]        sample_row   = '0;
	logic [POS_W-1:0]        sample_col   = '0;
	logic [SAMPLE_W-1:0]     sample_value = '0;
	logic signed [Q_W-1:0]   query_x      = '0;
	logic signed [Q_W-1:0]   query_z      = '0;
	logic                    done;
	logic signed [OUT_W-1:0] height;
	logic                    saturated;
	logic                    cfg_valid    = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index    = REG_GRID_ROWS;
	logic [CFG_DATA_W-1:0]   cfg_data     = '0;

	// Settings as last written, and the predicted contents of the height store.
	logic [DIM_W-1:0]  grid_rows_cfg = GRID_DIM_RESET;
	logic [DIM_W-1:0]  grid_cols_cfg = GRID_DIM_RESET;
	logic [GAIN_W-1:0] gain_cfg      = GAIN_RESET;
	logic [HGT_W-1:0]  grid_heights [STORE_DEPTH];

	// Store entries that requests already queued will have written.
	bit                sample_written [STORE_DEPTH];

	terrain_request_t pending_requests [$];
	height_result_t   expected_heights [$];
	int               planned_items  = 0;
	int               mismatch_count = 0;
	int               idle_left      = 0;
	int               calm_left      = 0;
	terrain_request_t active_req;

	terrain_height_query_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.sample_row  (sample_row),
		.sample_col  (sample_col),
		.sample_value(sample_value),
		.query_x     (query_x),
		.query_z     (query_z),
		.done        (done),
		.height      (height),
		.saturated   (saturated),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Grid sizes outside the supported range act as the nearest limit.
	function automatic int clamp_dim(input logic [DIM_W-1:0] d);
		if (d < 2) return 2;
		if (d > MAX_GRID_DIM) return MAX_GRID_DIM;
		return int'(d);
	endfunction

	// Find the cell a query falls in, clamped to the grid, and the offsets into it.
	task automatic locate_cell(input logic signed [Q_W-1:0] qx, input logic signed [Q_W-1:0] qz,
			output longint row, output longint col, output longint dx, output longint dz);
		longint rows, cols, sx, sz, cx, cz;
		rows = clamp_dim(grid_rows_cfg);
		cols = clamp_dim(grid_cols_cfg);
		sx = qx;
		sz = qz;
		cx = (cols - 1) * HALF_Q + sx;
		cz = (rows - 1) * HALF_Q - sz;
		col = cx >>> FRAC;
		row = cz >>> FRAC;
		if (col < 0) col = 0;
		if (row < 0) row = 0;
		if (col > cols - 2) col = cols - 2;
		if (row > rows - 2) row = rows - 2;
		dx = cx - col * ONE_Q;
		dz = cz - row * ONE_Q;
	endtask

	// Apply one accepted request to the predicted store, or predict its height.
	task automatic predict_terrain_request(input terrain_request_t req);
		longint rows, cols, row, col, dx, dz, v0, v1, v2, v3, acc, h, prod;
		height_result_t res;
		rows = clamp_dim(grid_rows_cfg);
		cols = clamp_dim(grid_cols_cfg);
		if (req.func == FUNC_WRITE) begin
			// Writes outside the grid in use are dropped.
			prod = req.value * gain_cfg;
			if (req.row < rows && req.col < cols)
				grid_heights[req.row * cols + req.col] = prod[HGT_W-1:0];
		end else begin
			locate_cell(req.qx, req.qz, row, col, dx, dz);
			v0 = grid_heights[row * cols + col];
			v1 = grid_heights[row * cols + col + 1];
			v2 = grid_heights[(row + 1) * cols + col];
			v3 = grid_heights[(row + 1) * cols + col + 1];
			// Interpolate over one of the two triangles; the sum is exact in Q.8.
			if (dx + dz < ONE_Q)
				acc = v0 * ONE_Q + (v1 - v0) * dx + (v2 - v0) * dz;
			else
				acc = v3 * ONE_Q + (v2 - v3) * (ONE_Q - dx) + (v1 - v3) * (ONE_Q - dz);
			h = (acc + ROUND_Q) >>> FRAC;
			res.saturated = 1'b0;
			if (h > HEIGHT_MAX) begin
				h = HEIGHT_MAX;
				res.saturated = 1'b1;
			end
			if (h < HEIGHT_MIN) begin
				h = HEIGHT_MIN;
				res.saturated = 1'b1;
			end
			res.height = h[OUT_W-1:0];
			expected_heights.push_back(res);
		end
	endtask

	function automatic terrain_request_t random_request();
		terrain_request_t req;
		req.func  = 1'($urandom);
		req.row   = POS_W'($urandom);
		req.col   = POS_W'($urandom);
		req.value = SAMPLE_W'($urandom);
		req.qx    = Q_W'($urandom);
		req.qz    = Q_W'($urandom);
		return req;
	endfunction

	// Queue a sample write; fields that a write ignores carry random bits.
	task automatic queue_write(input int row, input int col, input int value);
		terrain_request_t req;
		int cols;
		cols      = clamp_dim(grid_cols_cfg);
		req       = random_request();
		req.func  = FUNC_WRITE;
		req.row   = POS_W'(row);
		req.col   = POS_W'(col);
		req.value = SAMPLE_W'(value);
		if (row < clamp_dim(grid_rows_cfg) && col < cols)
			sample_written[row * cols + col] = 1'b1;
		pending_requests.push_back(req);
		planned_items++;
	endtask

	// Queue a query, preceded by writes to any of its corners not yet written.
	task automatic queue_query(input logic signed [Q_W-1:0] qx, input logic signed [Q_W-1:0] qz);
		terrain_request_t req;
		longint row, col, dx, dz, cols;
		cols = clamp_dim(grid_cols_cfg);
		locate_cell(qx, qz, row, col, dx, dz);
		for (int dr = 0; dr < 2; dr++) begin
			for (int dc = 0; dc < 2; dc++) begin
				if (!sample_written[(row + dr) * cols + col + dc])
					queue_write(int'(row + dr), int'(col + dc), $urandom_range(0, 255));
			end
		end
		req      = random_request();
		req.func = FUNC_QUERY;
		req.qx   = qx;
		req.qz   = qz;
		pending_requests.push_back(req);
		planned_items++;
	endtask

	// Wait until every request is taken and answered, then let writes drain.
	task automatic wait_idle();
		@(negedge clk);
		while (pending_requests.size() != 0 || start || expected_heights.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_GRID_ROWS:   grid_rows_cfg = data[DIM_W-1:0];
			REG_GRID_COLS:   grid_cols_cfg = data[DIM_W-1:0];
			REG_HEIGHT_GAIN: gain_cfg = data[GAIN_W-1:0];
			default: ;
		endcase
	endtask

	// Reprogram all settings once the block is idle; unused data bits are random.
	task automatic program_grid(input int rows, input int cols, input int gain);
		logic [CFG_DATA_W-1:0] data;
		wait_idle();
		data = CFG_DATA_W'($urandom);
		data[DIM_W-1:0] = DIM_W'(rows);
		write_reg(REG_GRID_ROWS, data);
		data = CFG_DATA_W'($urandom);
		data[DIM_W-1:0] = DIM_W'(cols);
		write_reg(REG_GRID_COLS, data);
		write_reg(REG_HEIGHT_GAIN, CFG_DATA_W'(gain));
		write_reg(REG_SPARE, CFG_DATA_W'($urandom));
		@(negedge clk);
	endtask

	// Grid sizes lean toward small grids, with the limits and bad values mixed in.
	function automatic int pick_dim();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(2, 12);
			4: return $urandom_range(0, 1);
			5: return MAX_GRID_DIM;
			6: return $urandom_range(MAX_GRID_DIM + 1, (1 << DIM_W) - 1);
			7: return $urandom_range(0, (1 << DIM_W) - 1);
			8: return 2;
			default: return $urandom_range(13, 64);
		endcase
	endfunction

	// Request driver: one request at a time from the pending queue, with random gaps.
	always @(posedge clk) begin : request_driver
		logic launch;
		launch = 1'b0;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				predict_terrain_request(active_req);
				if (calm_left > 0) begin
					calm_left--;
					idle_left = 0;
				end else begin
					idle_left = $urandom_range(0, 16);
					if ($urandom_range(0, 31) == 0)
						calm_left = $urandom_range(8, 48);
				end
			end
			if (!start || !busy) begin
				if (idle_left > 0)
					idle_left--;
				else if (pending_requests.size() != 0)
					launch = 1'b1;
			end
			if (launch) begin
				active_req = pending_requests.pop_front();
				start        <= 1'b1;
				func         <= active_req.func;
				sample_row   <= active_req.row;
				sample_col   <= active_req.col;
				sample_value <= active_req.value;
				query_x      <= active_req.qx;
				query_z      <= active_req.qz;
			end else if (!start || !busy) begin
				start <= 1'b0;
			end
		end
	end

	// Result monitor: each result is checked against the oldest predicted height.
	always @(posedge clk) begin : result_monitor
		height_result_t want;
		if (arst_n && done) begin
			if (expected_heights.size() == 0) begin
				$error("height: no query pending, got %0d", height);
				mismatch_count++;
			end else begin
				want = expected_heights.pop_front();
				if (height !== want.height) begin
					$error("height: expected %0d, got %0d", want.height, height);
					mismatch_count++;
				end
				if (saturated !== want.saturated) begin
					$error("saturated: expected %0b, got %0b", want.saturated, saturated);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : stimulus
		int rows, cols, gain, pick, stop, span_x, span_z;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Full-size grid after reset: corner hit, rounding tie, both triangles, far corners.
		queue_write(0, 0, 0);
		queue_write(0, 1, 1);
		queue_write(1, 0, 255);
		queue_write(1, 1, 128);
		queue_query(Q_W'(-CELL_ORIGIN), Q_W'(CELL_ORIGIN));
		queue_query(Q_W'(-CELL_ORIGIN + HALF_Q), Q_W'(CELL_ORIGIN));
		queue_query(Q_W'(-CELL_ORIGIN + 200), Q_W'(CELL_ORIGIN - 100));
		queue_query(Q_W'(-CELL_ORIGIN + 255), Q_W'(CELL_ORIGIN - 255));
		queue_query(Q_MIN, Q_MIN);
		queue_query(Q_MAX, Q_MAX);

		// Smallest grid at full gain: dropped writes and saturation both ways.
		program_grid(2, 2, GAIN_MAX);
		queue_write(2, 0, 77);
		queue_write(0, 255, 77);
		queue_write(255, 255, 255);
		queue_write(0, 0, 0);
		queue_write(0, 1, 255);
		queue_write(1, 0, 0);
		queue_write(1, 1, 0);
		queue_query(Q_MAX, Q_MAX);
		queue_query(Q_MIN, '0);
		queue_query('0, '0);

		// Random phases, each under its own grid size and gain.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin
					rows = 0;
					cols = (1 << DIM_W) - 1;
					gain = 0;
				end
				1: begin
					rows = MAX_GRID_DIM;
					cols = 2;
					gain = GAIN_MAX;
				end
				2: begin
					rows = 1;
					cols = 300;
					gain = $urandom_range(0, GAIN_MAX);
				end
				default: begin
					rows = pick_dim();
					cols = pick_dim();
					pick = $urandom_range(0, 7);
					gain = (pick == 0) ? 0 : (pick == 1) ? GAIN_MAX : $urandom_range(0, GAIN_MAX);
				end
			endcase
			program_grid(rows, cols, gain);
			rows   = clamp_dim(grid_rows_cfg);
			cols   = clamp_dim(grid_cols_cfg);
			span_x = (cols - 1) * ONE_Q;
			span_z = (rows - 1) * ONE_Q;
			stop   = planned_items + PHASE_ITEMS;
			while (planned_items < stop) begin
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					// Mostly inside the grid, with a small margin past each edge.
					queue_query(
						Q_W'($urandom_range(0, span_x + 4 * ONE_Q) - span_x / 2 - 2 * ONE_Q),
						Q_W'($urandom_range(0, span_z + 4 * ONE_Q) - span_z / 2 - 2 * ONE_Q));
				end else if (pick < 52) begin
					queue_query(Q_W'($urandom), Q_W'($urandom));
				end else if (pick < 90) begin
					queue_write($urandom_range(0, rows - 1), $urandom_range(0, cols - 1),
						$urandom_range(0, 255));
				end else begin
					queue_write($urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 255));
				end
			end
		end

		wait_idle();
		if (mismatch_count == 0 && expected_heights.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog for a hung handshake or a missing result.
	initial begin : watchdog
		#3000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
